/* src/vdifdf_pkg.sv */
`timescale 1ns / 1ps
// vdifdf_pkg: shared types and constants of the frame deframer with gap fill
// no dependencies; used by every module of the block

package vdifdf_pkg;

	// fixed field widths
	localparam int WORD_W      = 32;
	localparam int FRAME_NUM_W = 24;
	localparam int CLUSTER_W   = 17;
	localparam int OFFSET_W    = 9;
	localparam int FPS_W       = 24;
	localparam int CFG_DATA_W  = 24;
	localparam int CFG_IDX_W   = 2;
	// cluster position plus missing frame count never reaches 2^25
	localparam int MOD_DVD_W   = FRAME_NUM_W + 1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FRAME_IN_CL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_FRAMES    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_PER_SECOND = 2'd3;

	// configuration reset values
	localparam logic [CLUSTER_W-1:0] CLUSTER_FRAMES_RESET = 17'd102300;
	localparam logic [FPS_W-1:0]     FPS_RESET            = 24'd200000;

	typedef struct packed {
		logic [OFFSET_W-1:0]  start_offset;
		logic [CLUSTER_W-1:0] first_frame_in_cluster;
		logic [CLUSTER_W-1:0] cluster_frames;
		logic [FPS_W-1:0]     frames_per_second;
	} cfg_t;

	// operations passed from the front to the back
	typedef enum logic {
		OP_EMIT,
		OP_SKIP
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [WORD_W-1:0] data;
	} q_entry_t;

	// modulo unit request and response
	typedef struct packed {
		logic                 start;
		logic [MOD_DVD_W-1:0] dividend;
		logic [CLUSTER_W-1:0] divisor;
	} mod_req_t;

	typedef struct packed {
		logic                 busy;
		logic                 done;
		logic [CLUSTER_W-1:0] rem;
	} mod_rsp_t;

endpackage

/* src/vdifdf_mod_unit.sv */
`timescale 1ns / 1ps
// vdifdf_mod_unit: bit-serial restoring remainder for the cluster position
// depends on vdifdf_pkg

module vdifdf_mod_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  vdifdf_pkg::mod_req_t req,
	output vdifdf_pkg::mod_rsp_t rsp
);

	localparam int DvdW = vdifdf_pkg::MOD_DVD_W;
	localparam int DivW = vdifdf_pkg::CLUSTER_W;
	localparam int CntW = $clog2(DvdW);

	logic            busy_q;
	logic            done_q;
	logic [CntW-1:0] cnt_q;
	logic [DvdW-1:0] dvd_q;
	logic [DivW-1:0] div_q;
	logic [DivW-1:0] rem_q;

	logic [DivW:0]   step_sh;
	logic            step_ge;
	logic [DivW-1:0] rem_nxt;

	// one quotient bit per cycle, msb first
	always_comb begin
		step_sh = {rem_q, dvd_q[DvdW-1]};
		step_ge = step_sh >= {1'b0, div_q};
		rem_nxt = step_ge ? DivW'(step_sh - {1'b0, div_q}) : step_sh[DivW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CntW'(DvdW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			div_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DvdW-2:0], 1'b0};
			rem_q <= rem_nxt;
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

endmodule

/* src/vdifdf_queue.sv */
`timescale 1ns / 1ps
// vdifdf_queue: short register queue between front and back
// depends on vdifdf_pkg

module vdifdf_queue #(
	parameter int DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  vdifdf_pkg::q_entry_t push_entry,
	output logic                 full,
	input  logic                 pop,
	output vdifdf_pkg::q_entry_t head,
	output logic                 head_valid
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	vdifdf_pkg::q_entry_t entries_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	logic do_push;
	logic do_pop;

	assign full       = count_q == CntW'(DEPTH);
	assign head_valid = count_q != '0;
	assign head       = entries_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

/* src/vdifdf_front.sv */
`timescale 1ns / 1ps
// vdifdf_front: framing, frame number continuity and cluster position tracking
// depends on vdifdf_pkg; drives vdifdf_mod_unit and the queue

module vdifdf_front #(
	parameter int HEADER_WORDS  = 8,
	parameter int PAYLOAD_WORDS = 320,
	parameter int FILLER_WORDS  = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  vdifdf_pkg::cfg_t                     cfg,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [vdifdf_pkg::WORD_W-1:0]        stream_word,
	output vdifdf_pkg::mod_req_t                 mod_req,
	input  vdifdf_pkg::mod_rsp_t                 mod_rsp,
	output logic                                 push,
	output vdifdf_pkg::q_entry_t                 push_entry,
	input  logic                                 q_full
);

	localparam int HdrW  = $clog2(HEADER_WORDS);
	localparam int PcW   = $clog2(PAYLOAD_WORDS);
	localparam int FillW = (FILLER_WORDS > 0) ? $clog2(FILLER_WORDS + 1) : 1;
	localparam int CmpW  = (PcW > vdifdf_pkg::OFFSET_W) ? PcW : vdifdf_pkg::OFFSET_W;
	localparam int FnW   = vdifdf_pkg::FRAME_NUM_W;
	localparam int ClW   = vdifdf_pkg::CLUSTER_W;
	localparam int DvdW  = vdifdf_pkg::MOD_DVD_W;

	logic             started_q;
	logic             first_q;
	logic             in_payload_q;
	logic [HdrW-1:0]  hdr_idx_q;
	logic [PcW-1:0]   pc_q;
	logic [FillW-1:0] skip_q;
	logic [FnW-1:0]   cur_fn_q;
	logic [ClW-1:0]   cp_q;

	logic             accept;
	logic             is_skip;
	logic             is_header;
	logic             is_payload;
	logic [FnW-1:0]   next_fn;
	logic [FnW:0]     cur_plus1;
	logic [FnW:0]     next_plus_fps;
	logic             in_sequence;
	logic             gap_hit;
	logic [FnW-1:0]   missing;
	logic [ClW-1:0]   cluster_len;
	logic             emit_ok;
	logic             frame_end;

	always_comb begin
		accept        = in_valid && in_ready;
		is_skip       = skip_q != '0;
		is_header     = !is_skip && !in_payload_q;
		is_payload    = !is_skip && in_payload_q;
		next_fn       = stream_word[FnW-1:0];
		cur_plus1     = {1'b0, cur_fn_q} + 1'b1;
		next_plus_fps = {1'b0, next_fn} + {1'b0, cfg.frames_per_second};
		in_sequence   = (cur_plus1 == {1'b0, next_fn}) || (cur_plus1 == next_plus_fps);
		gap_hit       = accept && is_header && (hdr_idx_q == HdrW'(1)) && !first_q
			&& !in_sequence && (next_fn > cur_fn_q);
		missing       = next_fn - cur_fn_q - 1'b1;
		cluster_len   = (cfg.cluster_frames == '0) ? ClW'(1) : cfg.cluster_frames;
		emit_ok       = !(first_q && (CmpW'(pc_q) < CmpW'(cfg.start_offset)));
		frame_end     = pc_q == PcW'(PAYLOAD_WORDS - 1);
	end

	// the modulo unit owns the cluster position while it runs
	assign in_ready = !mod_rsp.busy && !mod_rsp.done && !q_full;

	always_comb begin
		mod_req.start    = accept && (!started_q || gap_hit);
		mod_req.divisor  = cluster_len;
		mod_req.dividend = !started_q ? DvdW'(cfg.first_frame_in_cluster)
			: DvdW'(cp_q) + DvdW'(missing);
	end

	always_comb begin
		push            = gap_hit || (accept && is_payload && emit_ok);
		push_entry.op   = gap_hit ? vdifdf_pkg::OP_SKIP : vdifdf_pkg::OP_EMIT;
		push_entry.data = gap_hit ? vdifdf_pkg::WORD_W'(missing) : stream_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q    <= 1'b0;
			first_q      <= 1'b1;
			in_payload_q <= 1'b0;
			hdr_idx_q    <= '0;
			pc_q         <= '0;
			skip_q       <= '0;
			cur_fn_q     <= '0;
			cp_q         <= '0;
		end else begin
			if (mod_rsp.done) begin
				cp_q <= mod_rsp.rem;
			end
			if (accept) begin
				started_q <= 1'b1;
				if (is_skip) begin
					skip_q <= skip_q - 1'b1;
				end else if (!in_payload_q) begin
					if (hdr_idx_q == HdrW'(1)) begin
						cur_fn_q <= next_fn;
					end
					if (hdr_idx_q == HdrW'(HEADER_WORDS - 1)) begin
						hdr_idx_q    <= '0;
						in_payload_q <= 1'b1;
						pc_q         <= '0;
					end else begin
						hdr_idx_q <= hdr_idx_q + 1'b1;
					end
				end else begin
					if (frame_end) begin
						pc_q         <= '0;
						in_payload_q <= 1'b0;
						first_q      <= 1'b0;
						if (cp_q >= cluster_len - 1'b1) begin
							cp_q   <= '0;
							skip_q <= FillW'(FILLER_WORDS);
						end else begin
							cp_q <= cp_q + 1'b1;
						end
					end else begin
						pc_q <= pc_q + 1'b1;
					end
				end
			end
		end
	end

endmodule

/* src/vdifdf_back.sv */
`timescale 1ns / 1ps
// vdifdf_back: output address, gap skip arithmetic and the output register
// depends on vdifdf_pkg; fed from vdifdf_queue

module vdifdf_back #(
	parameter int PAYLOAD_WORDS = 320,
	parameter int ADDRESS_BITS  = 27
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  vdifdf_pkg::q_entry_t          head,
	input  logic                          head_valid,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [vdifdf_pkg::WORD_W-1:0] data_word,
	output logic [ADDRESS_BITS-1:0]       word_address,
	output logic                          after_gap
);

	localparam int FnW   = vdifdf_pkg::FRAME_NUM_W;
	localparam int ProdW = FnW + $clog2(PAYLOAD_WORDS + 1);
	localparam int SumW  = ((ADDRESS_BITS + 1 > ProdW) ? ADDRESS_BITS + 1 : ProdW) + 1;
	localparam logic [ADDRESS_BITS:0] AddrLimit = {1'b1, {ADDRESS_BITS{1'b0}}};

	logic [ADDRESS_BITS:0]          addr_q;
	logic                           gap_q;
	logic                           skip_busy_s1;
	logic [ProdW-1:0]               prod_s1;
	logic                           out_valid_q;
	logic [vdifdf_pkg::WORD_W-1:0]  data_q;
	logic [ADDRESS_BITS-1:0]        out_addr_q;
	logic                           out_gap_q;

	logic                           addr_full;
	logic                           out_free;
	logic                           load_out;
	logic                           take_skip;
	logic [SumW-1:0]                addr_sum;
	logic [ADDRESS_BITS:0]          addr_sat;

	always_comb begin
		addr_full = addr_q[ADDRESS_BITS];
		out_free  = !out_valid_q || out_ready;
		pop       = 1'b0;
		load_out  = 1'b0;
		take_skip = 1'b0;
		if (!skip_busy_s1 && head_valid) begin
			unique case (head.op)
				vdifdf_pkg::OP_SKIP: begin
					pop       = 1'b1;
					take_skip = 1'b1;
				end
				vdifdf_pkg::OP_EMIT: begin
					if (addr_full) begin
						pop = 1'b1;
					end else if (out_free) begin
						pop      = 1'b1;
						load_out = 1'b1;
					end
				end
			endcase
		end
		addr_sum = SumW'(addr_q) + SumW'(prod_s1);
		addr_sat = (addr_sum > SumW'(AddrLimit)) ? AddrLimit : addr_sum[ADDRESS_BITS:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q       <= '0;
			gap_q        <= 1'b0;
			skip_busy_s1 <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			skip_busy_s1 <= take_skip;
			if (skip_busy_s1) begin
				addr_q <= addr_sat;
				gap_q  <= 1'b1;
			end else if (load_out) begin
				addr_q <= addr_q + 1'b1;
				gap_q  <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_skip) begin
			prod_s1 <= ProdW'(head.data[FnW-1:0]) * ProdW'(PAYLOAD_WORDS);
		end
		if (load_out) begin
			data_q     <= head.data;
			out_addr_q <= addr_q[ADDRESS_BITS-1:0];
			out_gap_q  <= gap_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign data_word    = data_q;
	assign word_address = out_addr_q;
	assign after_gap    = out_gap_q;

endmodule

/* src/vdif_deframer_gap_fill_top.sv */
`timescale 1ns / 1ps
// vdif_deframer_gap_fill_top: top level of the frame deframer with gap fill
// depends on vdifdf_pkg, vdifdf_mod_unit, vdifdf_queue, vdifdf_front, vdifdf_back

// usage
// - input channel in_valid/in_ready/stream_word carries the recorded word stream,
//   which must begin at a frame header; one word per item
// - output channel out_valid/out_ready carries payload words with their buffer
//   word address and a mark on the first word after a frame number jump
// - configuration is a plain write port (cfg_write_en, cfg_index, cfg_data),
//   written only while the block is idle; values take effect on the next word
// - an accepted payload word is registered in a queue entry and then in the
//   output register, from which it shows at the output
// - throughput: one word per cycle while the queue has room; the first word of
//   the stream and every header with a forward frame jump hold off the input
//   while the bit-serial modulo unit (25 steps plus hand-off) recomputes the
//   cluster position; on a jump the back end also registers the multiply
// - a four-entry queue parts the framing front from the address back end, so
//   headers and filler keep streaming in while the receiver stalls, until the
//   queue fills
// - reset returns configuration to its defaults and restarts framing at a
//   header; no clearing pass is needed
// - words whose address would pass the top of the address range are dropped

module vdif_deframer_gap_fill_top #(
	parameter int HEADER_WORDS  = 8,
	parameter int PAYLOAD_WORDS = 320,
	parameter int FILLER_WORDS  = 32,
	parameter int ADDRESS_BITS  = 27,
	parameter int QUEUE_DEPTH   = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [vdifdf_pkg::WORD_W-1:0]     stream_word,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [vdifdf_pkg::WORD_W-1:0]     data_word,
	output logic [ADDRESS_BITS-1:0]           word_address,
	output logic                              after_gap,
	input  logic                              cfg_write_en,
	input  logic [vdifdf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [vdifdf_pkg::CFG_DATA_W-1:0] cfg_data
);

	vdifdf_pkg::cfg_t     cfg_q;
	vdifdf_pkg::mod_req_t mod_req;
	vdifdf_pkg::mod_rsp_t mod_rsp;
	vdifdf_pkg::q_entry_t push_entry;
	vdifdf_pkg::q_entry_t head;
	logic                 push;
	logic                 q_full;
	logic                 pop;
	logic                 head_valid;

	// configuration registers, each keeps only its own width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_offset           <= '0;
			cfg_q.first_frame_in_cluster <= '0;
			cfg_q.cluster_frames         <= vdifdf_pkg::CLUSTER_FRAMES_RESET;
			cfg_q.frames_per_second      <= vdifdf_pkg::FPS_RESET;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				vdifdf_pkg::CFG_START_OFFSET: begin
					cfg_q.start_offset <= cfg_data[vdifdf_pkg::OFFSET_W-1:0];
				end
				vdifdf_pkg::CFG_FIRST_FRAME_IN_CL: begin
					cfg_q.first_frame_in_cluster <= cfg_data[vdifdf_pkg::CLUSTER_W-1:0];
				end
				vdifdf_pkg::CFG_CLUSTER_FRAMES: begin
					cfg_q.cluster_frames <= cfg_data[vdifdf_pkg::CLUSTER_W-1:0];
				end
				vdifdf_pkg::CFG_FRAMES_PER_SECOND: begin
					cfg_q.frames_per_second <= cfg_data[vdifdf_pkg::FPS_W-1:0];
				end
			endcase
		end
	end

	// front: word classification, continuity test, cluster position
	vdifdf_front #(
		.HEADER_WORDS (HEADER_WORDS),
		.PAYLOAD_WORDS(PAYLOAD_WORDS),
		.FILLER_WORDS (FILLER_WORDS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.stream_word(stream_word),
		.mod_req    (mod_req),
		.mod_rsp    (mod_rsp),
		.push       (push),
		.push_entry (push_entry),
		.q_full     (q_full)
	);

	// shared modulo for the start index and for cluster position after a jump
	vdifdf_mod_unit u_mod (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (mod_req),
		.rsp   (mod_rsp)
	);

	// emit and skip operations in stream order
	vdifdf_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.full      (q_full),
		.pop       (pop),
		.head      (head),
		.head_valid(head_valid)
	);

	// back: address counter with saturating skip, output register
	vdifdf_back #(
		.PAYLOAD_WORDS(PAYLOAD_WORDS),
		.ADDRESS_BITS (ADDRESS_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.head_valid  (head_valid),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.data_word   (data_word),
		.word_address(word_address),
		.after_gap   (after_gap)
	);

endmodule

/* src/vdifdf_checker.sv */
`timescale 1ns / 1ps
// vdifdf_checker: port-level assertions for the deframer top level
// depends on vdifdf_pkg; bound to vdif_deframer_gap_fill_top

module vdifdf_checker #(
	parameter int ADDRESS_BITS = 27
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [vdifdf_pkg::WORD_W-1:0] data_word,
	input logic [ADDRESS_BITS-1:0]       word_address,
	input logic                          after_gap
);

	// reset empties the output register
	a_reset_clears_out: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("output valid during reset");

	// a stalled result holds
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(data_word)
			&& $stable(word_address) && $stable(after_gap))
		else $error("stalled result changed");

	// without a jump, addresses of back-to-back words run on by one
	a_addr_step: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready) ##1 (out_valid && !after_gap)
			|-> word_address == ADDRESS_BITS'($past(word_address) + 1'b1))
		else $error("address did not advance by one");

	// only the first word after a jump is marked
	a_gap_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && after_gap |=> !(out_valid && after_gap))
		else $error("gap mark on two words in a row");

endmodule

bind vdif_deframer_gap_fill_top vdifdf_checker #(
	.ADDRESS_BITS(ADDRESS_BITS)
) u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.data_word   (data_word),
	.word_address(word_address),
	.after_gap   (after_gap)
);

/* tb/sv/vdif_deframer_gap_fill_top_tb.sv */
`timescale 1ns / 1ps
// vdif_deframer_gap_fill_top_tb: self-checking bench for the frame deframer with gap fill
// depends on vdifdf_pkg and vdif_deframer_gap_fill_top; drives a framed word stream with
// random stalls and checks every payload word, address and gap mark against its own predictor

module vdif_deframer_gap_fill_top_tb;
	import vdifdf_pkg::*;

	// block geometry, kept at the defaults of the top level
	localparam int HDR_WORDS  = 8;
	localparam int PAY_WORDS  = 320;
	localparam int FILL_WORDS = 32;
	localparam int ADDR_W     = 27;

	localparam longint unsigned        ADDR_TOP = 64'd1 << ADDR_W;
	localparam logic [FRAME_NUM_W-1:0] NUM_MASK = 24'hFFFFFF;

	localparam int CLK_PERIOD    = 2;
	// idle cycles in a row with no item moving on either side before the run is abandoned;
	// a correct run never idles more than the send gap, the modulo hold-off,
	// a receiver stall and the settle pause between settings, all well under this
	localparam int IDLE_LIMIT    = 2000;
	// covers the queue and output registers, the modulo unit and the jump multiply after the last word
	localparam int SETTLE_CYCLES = 64;
	localparam int REPORT_MAX    = 10;

	// one expected payload word
	typedef struct packed {
		logic [WORD_W-1:0] data;
		logic [ADDR_W-1:0] addr;
		logic              gap;
	} payload_rec_t;

	// how the frame number of the next header is chosen
	typedef enum int {
		FN_HIGH,   // fixed value near the top of the 24-bit range
		FN_NEXT,   // current plus one, wrapping in 24 bits
		FN_SAME,   // same number again
		FN_OLDER,  // any number not above the current one
		FN_GAP,    // a few frames missing
		FN_WRAP,   // current plus one minus the frame modulus, else current plus one
		FN_HOP,    // up to a couple of thousand frames missing
		FN_EDGE,   // jump that puts the address just below the top of the range
		FN_TOP     // jump far past the top of the address range
	} frame_num_mode_t;

	// predictor of the deframer plus the store of payload words still to come out
	class deframe_scoreboard;
		// register copies, reset values as in the block
		logic [OFFSET_W-1:0]    start_off   = '0;
		logic [CLUSTER_W-1:0]   first_idx   = '0;
		logic [CLUSTER_W-1:0]   clus_frames = CLUSTER_FRAMES_RESET;
		logic [FPS_W-1:0]       frame_mod   = FPS_RESET;
		// framing state
		int unsigned            pay_idx     = 0;
		int unsigned            filler_left = 0;
		int unsigned            hdr_idx     = 0;
		logic [FRAME_NUM_W-1:0] cur_num     = '0;
		logic [CLUSTER_W-1:0]   clus_pos    = '0;
		longint unsigned        out_addr    = 0;
		bit                     gap_mark    = 0;
		bit                     in_payload  = 0;
		bit                     started     = 0;
		bit                     first_frame = 1;
		payload_rec_t           expected_words[$];
		// statistics
		int                     errors  = 0;
		int                     matched = 0;
		int                     marked  = 0;
		int                     jumps   = 0;
		int                     fillers = 0;
		int                     frames  = 0;

		// a cluster length of zero behaves as one
		function int unsigned clus_len();
			return (clus_frames == 0) ? 1 : clus_frames;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				CFG_START_OFFSET:      start_off   = val[OFFSET_W-1:0];
				CFG_FIRST_FRAME_IN_CL: first_idx   = val[CLUSTER_W-1:0];
				CFG_CLUSTER_FRAMES:    clus_frames = val[CLUSTER_W-1:0];
				CFG_FRAMES_PER_SECOND: frame_mod   = val[FPS_W-1:0];
				default: ;
			endcase
		endfunction

		// continuity test on a new frame number; only a larger number that is not
		// the successor moves the address and the cluster position
		function void frame_jump(logic [FRAME_NUM_W-1:0] num);
			longint unsigned succ;
			longint unsigned missing;
			longint unsigned a;
			succ = 64'(cur_num) + 64'd1;
			if (succ == 64'(num) || succ == 64'(num) + 64'(frame_mod))
				return;
			if (num > cur_num) begin
				missing  = 64'(num) - 64'(cur_num) - 64'd1;
				a        = out_addr + missing * 64'(PAY_WORDS);
				out_addr = (a > ADDR_TOP) ? ADDR_TOP : a;
				clus_pos = CLUSTER_W'((64'(clus_pos) + missing) % 64'(clus_len()));
				gap_mark = 1;
				jumps++;
			end
		endfunction

		// one accepted stream word
		function void note_word(logic [WORD_W-1:0] w);
			bit emit;
			if (!started) begin
				started     = 1;
				first_frame = 1;
				clus_pos    = CLUSTER_W'(first_idx % clus_len());
			end
			if (filler_left > 0) begin
				filler_left--;
				fillers++;
				return;
			end
			if (!in_payload) begin
				if (hdr_idx == 1) begin
					if (!first_frame)
						frame_jump(w[FRAME_NUM_W-1:0]);
					cur_num = w[FRAME_NUM_W-1:0];
				end
				hdr_idx++;
				if (hdr_idx >= HDR_WORDS) begin
					hdr_idx    = 0;
					in_payload = 1;
					pay_idx    = 0;
				end
				return;
			end
			emit = !(first_frame && pay_idx < start_off) && out_addr < ADDR_TOP;
			pay_idx++;
			if (pay_idx >= PAY_WORDS) begin
				pay_idx     = 0;
				in_payload  = 0;
				first_frame = 0;
				frames++;
				if (clus_pos >= clus_len() - 1) begin
					clus_pos    = '0;
					filler_left = FILL_WORDS;
				end else begin
					clus_pos++;
				end
			end
			if (emit) begin
				expected_words.push_back('{data: w, addr: ADDR_W'(out_addr), gap: gap_mark});
				out_addr++;
				gap_mark = 0;
			end
		endfunction

		// one accepted output item against the oldest expected word
		function void check_result(logic [WORD_W-1:0] d, logic [ADDR_W-1:0] a, logic g);
			payload_rec_t want;
			if (expected_words.size() == 0) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("unexpected output item: data %h addr %h gap %b", d, a, g);
				return;
			end
			want = expected_words.pop_front();
			if (want.data !== d || want.addr !== a || want.gap !== g) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("mismatch: expected data %h addr %h gap %b, got data %h addr %h gap %b",
						want.data, want.addr, want.gap, d, a, g);
			end else begin
				matched++;
				if (g)
					marked++;
			end
		endfunction

		function int pending();
			return expected_words.size();
		endfunction
	endclass

	// clock, reset and block inputs, all known from time zero
	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  in_valid     = 1'b0;
	logic [WORD_W-1:0]     stream_word  = '0;
	logic                  out_ready    = 1'b0;
	logic                  cfg_write_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index    = CFG_START_OFFSET;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;

	logic                  in_ready;
	logic                  out_valid;
	logic [WORD_W-1:0]     data_word;
	logic [ADDR_W-1:0]     word_address;
	logic                  after_gap;

	deframe_scoreboard     sb = new();

	// header number choices forced ahead of the random ones
	frame_num_mode_t       forced_modes[$];
	// payload words forced at the start of the stream
	logic [WORD_W-1:0]     pattern_words[$];

	bit                    steady      = 0;  // both sides run without gaps
	int                    words_in    = 0;
	int                    words_out   = 0;
	int                    reg_writes  = 0;
	int                    settings    = 0;
	int                    seen_total  = 0;
	int                    idle_cycles = 0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	vdif_deframer_gap_fill_top #(
		.HEADER_WORDS (HDR_WORDS),
		.PAYLOAD_WORDS(PAY_WORDS),
		.FILLER_WORDS (FILL_WORDS),
		.ADDRESS_BITS (ADDR_W)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.stream_word (stream_word),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.data_word   (data_word),
		.word_address(word_address),
		.after_gap   (after_gap),
		.cfg_write_en(cfg_write_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	// pick how the next header numbers its frame
	function automatic frame_num_mode_t pick_mode();
		int unsigned r;
		if (forced_modes.size() > 0)
			return forced_modes.pop_front();
		r = $urandom_range(0, 99);
		if (r < 45)
			return FN_NEXT;
		if (r < 60)
			return FN_GAP;
		if (r < 70)
			return FN_WRAP;
		if (r < 80)
			return FN_OLDER;
		if (r < 85)
			return FN_SAME;
		return FN_HOP;
	endfunction

	// frame number for the next header, from the predicted current number
	function automatic logic [FRAME_NUM_W-1:0] frame_number(input frame_num_mode_t mode);
		longint unsigned cur;
		longint unsigned nxt;
		longint unsigned room;
		cur = 64'(sb.cur_num);
		nxt = cur + 1;
		case (mode)
			FN_HIGH:  nxt = 64'(NUM_MASK) - 1;
			FN_SAME:  nxt = cur;
			FN_OLDER: nxt = $urandom_range(0, 32'(cur));
			FN_GAP:   nxt = cur + $urandom_range(2, 4);
			FN_WRAP: begin
				if (cur + 1 >= 64'(sb.frame_mod))
					nxt = cur + 1 - 64'(sb.frame_mod);
			end
			FN_HOP:   nxt = cur + $urandom_range(5, 2000);
			FN_EDGE: begin
				// land the address within one frame of the top so the frame crosses it
				if (sb.out_addr < ADDR_TOP) begin
					room = (ADDR_TOP - 1 - sb.out_addr) / PAY_WORDS;
					if (room > 0 && cur + 1 + room <= 64'(NUM_MASK))
						nxt = cur + 1 + room;
				end
			end
			FN_TOP:   nxt = 64'(NUM_MASK);
			default: ;
		endcase
		return nxt[FRAME_NUM_W-1:0];
	endfunction

	// next stream word; the predictor tells where in the frame the stream stands
	function automatic logic [WORD_W-1:0] next_word();
		logic [WORD_W-1:0] w;
		w = $urandom();
		if (sb.filler_left == 0 && !sb.in_payload && sb.hdr_idx == 1)
			w[FRAME_NUM_W-1:0] = frame_number(pick_mode());
		else if (sb.filler_left == 0 && sb.in_payload && pattern_words.size() > 0)
			w = pattern_words.pop_front();
		return w;
	endfunction

	// offer one stream word, with a random gap before it, and note it once accepted
	task automatic drive_word(input logic [WORD_W-1:0] w);
		int unsigned hold;
		bit          rdy;
		hold = steady ? 0 : $urandom_range(0, 8);
		if (hold > 0) begin
			in_valid <= 1'b0;
			repeat (hold) @(posedge clk);
		end
		in_valid    <= 1'b1;
		stream_word <= w;
		// ready is sampled mid-cycle, where it is settled for the coming edge
		forever begin
			@(negedge clk);
			rdy = (in_ready === 1'b1);
			@(posedge clk);
			if (rdy)
				break;
		end
		sb.note_word(w);
		words_in++;
	endtask

	task automatic run_words(input int n);
		repeat (n) drive_word(next_word());
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_write_en <= 1'b1;
		cfg_index    <= idx;
		cfg_data     <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
		reg_writes++;
	endtask

	// hold the stream until every expected word is out and the block has gone quiet,
	// then load a new register setting
	task automatic new_setting(input logic [CFG_DATA_W-1:0] off, input logic [CFG_DATA_W-1:0] ffc,
		input logic [CFG_DATA_W-1:0] clus, input logic [CFG_DATA_W-1:0] fps);
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(CFG_START_OFFSET, off);
		write_reg(CFG_FIRST_FRAME_IN_CL, ffc);
		write_reg(CFG_CLUSTER_FRAMES, clus);
		write_reg(CFG_FRAMES_PER_SECOND, fps);
		cfg_write_en <= 1'b0;
		settings++;
	endtask

	// output side: random stall before each item, then take it and check it
	initial begin : result_sink
		int unsigned       stall;
		bit                took;
		logic [WORD_W-1:0] got_data;
		logic [ADDR_W-1:0] got_addr;
		logic              got_gap;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 8);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			forever begin
				@(negedge clk);
				took     = (out_valid === 1'b1);
				got_data = data_word;
				got_addr = word_address;
				got_gap  = after_gap;
				@(posedge clk);
				if (took)
					break;
			end
			sb.check_result(got_data, got_addr, got_gap);
			words_out++;
		end
	end

	// watchdog: abandon the run when no item moves on either side for too long
	always @(negedge clk) begin
		if (words_in + words_out != seen_total) begin
			seen_total  = words_in + words_out;
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("no item moved for %0d cycles, %0d words still expected",
					IDLE_LIMIT, sb.pending());
				$display("vdif_deframer_gap_fill_top_tb failed");
				$finish;
			end
		end
	end

	initial begin : stimulus
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// first headers: near the top of the number range, its successor, then the 24-bit wrap to zero
		// (a smaller number, only adopted), the same number again, then a short gap
		forced_modes = '{FN_HIGH, FN_NEXT, FN_NEXT, FN_SAME, FN_GAP};
		// extremes of the data word; the first three fall under the start offset
		pattern_words = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
			32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0001, 32'h7FFF_FFFE};

		// short clusters with the first index far past the cluster length, widest modulus
		new_setting(3, 131071, 3, 24'hFFFFFF);
		run_words(HDR_WORDS + 20);

		// offset raised mid first frame: only the last payload word of that frame comes out
		new_setting(319, 131071, 3, 24'hFFFFFF);
		run_words(700);

		// widest offset (no longer matters), cluster length zero, modulus one
		new_setting(511, 0, 0, 1);
		run_words(400);

		// longest cluster and a small modulus, with neither side idling
		steady = 1;
		new_setting(0, 5, 131071, 10);
		run_words(500);
		steady = 0;

		// random setting, stray upper bits in the register data
		new_setting($urandom_range(0, 24'hFFFFFF), $urandom_range(0, 24'hFFFFFF),
			{7'($urandom()), 17'($urandom_range(1, 4))}, $urandom_range(1, 5000));
		run_words(500);

		// address range: land just below the top, cross it, then jump far past it
		forced_modes = '{FN_EDGE, FN_TOP};
		new_setting($urandom_range(0, 319), $urandom_range(0, 131071), 2, 200000);
		run_words(800);

		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("stream of %0d words over %0d register settings: %0d frames, %0d filler words,",
			words_in, settings, sb.frames, sb.fillers);
		$display("%0d frame number jumps, %0d payload words matched (%0d marked), %0d mismatches",
			sb.jumps, sb.matched, sb.marked, sb.errors);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("vdif_deframer_gap_fill_top_tb passed");
		else
			$display("vdif_deframer_gap_fill_top_tb failed");
		$finish;
	end

endmodule
